/* hdl/resource_quota_checker_assert.svh */
// Assertion macros used by the checker file rqc_checker.sv.
`ifndef RESOURCE_QUOTA_CHECKER_ASSERT_SVH
`define RESOURCE_QUOTA_CHECKER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define RQC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RQC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/rqc_pkg.sv */
`timescale 1ns / 1ps

package rqc_pkg;

    localparam int MEM_W    = 48;
    localparam int INSTR_W  = 48;
    localparam int DEPTH_W  = 16;
    localparam int TIME_W   = 32;
    localparam int AMOUNT_W = 48;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 3;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 48;

    // Stream widths; the data widths are padded to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 152;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_SINGLE_ALLOC = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_MEMORY_TOTAL = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_INSTR_COUNT  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_FRAME_DEPTH  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_TIME_MS      = 3'd4;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 3'd0,
        OP_FREE  = 3'd1,
        OP_EXEC  = 3'd2,
        OP_PUSH  = 3'd3,
        OP_POP   = 3'd4,
        OP_TICK  = 3'd5,
        OP_CLEAR = 3'd6
    } rqc_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_ALLOC_BIG = 3'd1,
        ST_MEM_LIMIT = 3'd2,
        ST_INSTR_LIM = 3'd3,
        ST_STACK     = 3'd4
    } rqc_status_t;

    typedef struct packed {
        logic [MEM_W-1:0]   max_single_alloc;
        logic [MEM_W-1:0]   max_memory_total;
        logic [INSTR_W-1:0] max_instr_count;
        logic [DEPTH_W-1:0] max_frame_depth;
        logic [TIME_W-1:0]  max_time_ms;
    } rqc_cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]  elapsed_ms;
        logic [DEPTH_W-1:0] frame_depth;
        logic [INSTR_W-1:0] instructions_done;
        logic [MEM_W-1:0]   memory_in_use;
        logic               time_expired;
        rqc_status_t        status;
    } rqc_result_t;

endpackage

/* hdl/rqc_cfg_regs.sv */
`timescale 1ns / 1ps

module rqc_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [rqc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [rqc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output rqc_pkg::rqc_cfg_t              cfg
);
    import rqc_pkg::*;

    rqc_cfg_t cfg_reg;
    rqc_cfg_t cfg_next;

    // Decode the write index; ignore indexes past the last register
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                CFG_MAX_SINGLE_ALLOC: cfg_next.max_single_alloc = cfg_wdata[MEM_W-1:0];
                CFG_MAX_MEMORY_TOTAL: cfg_next.max_memory_total = cfg_wdata[MEM_W-1:0];
                CFG_MAX_INSTR_COUNT:  cfg_next.max_instr_count  = cfg_wdata[INSTR_W-1:0];
                CFG_MAX_FRAME_DEPTH:  cfg_next.max_frame_depth  = cfg_wdata[DEPTH_W-1:0];
                CFG_MAX_TIME_MS:      cfg_next.max_time_ms      = cfg_wdata[TIME_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/rqc_engine.sv */
`timescale 1ns / 1ps

module rqc_engine (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         fire,
    input  rqc_pkg::rqc_op_t             op,
    input  logic [rqc_pkg::AMOUNT_W-1:0] amount,
    input  rqc_pkg::rqc_cfg_t            cfg,
    output rqc_pkg::rqc_result_t         res
);
    import rqc_pkg::*;

    logic [MEM_W-1:0]   mem_reg,   mem_next;
    logic [INSTR_W-1:0] instr_reg, instr_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [TIME_W-1:0]  ticks_reg, ticks_next;
    rqc_status_t        status;

    logic [MEM_W:0]   mem_sum;
    logic [INSTR_W:0] instr_sum;
    logic             alloc_big;

    // Form the exact sums one bit wider so that no limit check wraps
    assign mem_sum   = {1'b0, mem_reg} + {1'b0, amount};
    assign instr_sum = {1'b0, instr_reg} + {1'b0, amount};
    assign alloc_big = (cfg.max_single_alloc != '0) && (amount > cfg.max_single_alloc);

    // Apply one event to the counters
    always_comb begin
        mem_next   = mem_reg;
        instr_next = instr_reg;
        depth_next = depth_reg;
        ticks_next = ticks_reg;
        status     = ST_OK;
        case (op)
            OP_ALLOC: begin
                if (alloc_big) begin
                    status = ST_ALLOC_BIG;
                end else if (cfg.max_memory_total == '0) begin
                    mem_next = mem_sum[MEM_W] ? '1 : mem_sum[MEM_W-1:0];
                end else if (mem_sum > {1'b0, cfg.max_memory_total}) begin
                    status = ST_MEM_LIMIT;
                end else begin
                    mem_next = mem_sum[MEM_W-1:0];
                end
            end
            OP_FREE: begin
                mem_next = (amount > mem_reg) ? '0 : (mem_reg - amount);
            end
            OP_EXEC: begin
                if ((cfg.max_instr_count != '0) && (instr_sum > {1'b0, cfg.max_instr_count})) begin
                    status = ST_INSTR_LIM;
                end
                instr_next = instr_sum[INSTR_W] ? '1 : instr_sum[INSTR_W-1:0];
            end
            OP_PUSH: begin
                if ((cfg.max_frame_depth != '0) && (depth_reg >= cfg.max_frame_depth)) begin
                    status = ST_STACK;
                end else if (depth_reg != '1) begin
                    depth_next = depth_reg + 1'b1;
                end
            end
            OP_POP: begin
                if (depth_reg != '0) begin
                    depth_next = depth_reg - 1'b1;
                end
            end
            OP_TICK: begin
                if (ticks_reg != '1) begin
                    ticks_next = ticks_reg + 1'b1;
                end
            end
            OP_CLEAR: begin
                mem_next   = '0;
                instr_next = '0;
                depth_next = '0;
                ticks_next = '0;
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    // Commit the counters when the event leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_reg   <= '0;
            instr_reg <= '0;
            depth_reg <= '0;
            ticks_reg <= '0;
        end else if (fire) begin
            mem_reg   <= mem_next;
            instr_reg <= instr_next;
            depth_reg <= depth_next;
            ticks_reg <= ticks_next;
        end
    end

    // Report the counters as they stand after the event
    always_comb begin
        res.status            = status;
        res.time_expired      = (cfg.max_time_ms != '0) && (ticks_next >= cfg.max_time_ms);
        res.memory_in_use     = mem_next;
        res.instructions_done = instr_next;
        res.frame_depth       = depth_next;
        res.elapsed_ms        = ticks_next;
    end

endmodule

/* hdl/resource_quota_checker.sv */
`timescale 1ns / 1ps

// Runtime quota checker: each request on the slave stream is one event (allocate, free,
// execute batch, push, pop, tick, clear) and yields exactly one result on the master stream
// carrying a status code and the four counters after the event. One request is taken every
// cycle unless the result stream stalls; the input register feeds the counter update, whose
// result is captured in the output register. Limits must be set through the write port only
// while the stream is idle (not enforced by the block); a limit of zero means unlimited.
module resource_quota_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [rqc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [rqc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Event stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rqc_pkg::S_TDATA_W-1:0]   s_tdata,  // [47:0] amount
    input  logic [rqc_pkg::S_TUSER_W-1:0]   s_tuser,  // [2:0] op
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] status, [3] time_expired, [51:4] memory_in_use, [99:52] instructions_done,
    // [115:100] frame_depth, [147:116] elapsed_ms, [151:148] zero
    output logic [rqc_pkg::M_TDATA_W-1:0]   m_tdata
);
    import rqc_pkg::*;

    logic                in_valid_reg, in_valid_next;
    rqc_op_t             in_op_reg;
    logic [AMOUNT_W-1:0] in_amount_reg;
    logic                out_valid_reg, out_valid_next;
    rqc_result_t         out_res_reg;

    logic        advance;
    logic        fire;
    logic        s_accept;
    rqc_cfg_t    cfg;
    rqc_result_t res;

    rqc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rqc_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .op      (in_op_reg),
        .amount  (in_amount_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Move the request forward whenever the output register is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the request and hold the result
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg     <= rqc_op_t'(s_tuser[OP_W-1:0]);
            in_amount_reg <= s_tdata[AMOUNT_W-1:0];
        end
        if (fire) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - $bits(rqc_result_t)){1'b0}}, out_res_reg};

endmodule

/* hdl/rqc_checker.sv */
`timescale 1ns / 1ps
`include "resource_quota_checker_assert.svh"

module rqc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [rqc_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic [rqc_pkg::S_TUSER_W-1:0]   s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rqc_pkg::M_TDATA_W-1:0]   m_tdata
);
    import rqc_pkg::*;

    logic [STATUS_W-1:0] st;
    assign st = m_tdata[STATUS_W-1:0];

    // Reset empties the result side
    `RQC_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // A stalled result holds
    `RQC_ASSERT(a_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")

    // Status codes stay within the defined set
    `RQC_ASSERT(a_status, aclk, aresetn, m_tvalid |-> (st == ST_OK || st == ST_ALLOC_BIG || st == ST_MEM_LIMIT || st == ST_INSTR_LIM || st == ST_STACK), "undefined status")

    // An expired timer implies a nonzero elapsed count
    `RQC_ASSERT(a_time, aclk, aresetn, (m_tvalid && m_tdata[3]) |-> (m_tdata[147:116] != '0), "expired with zero elapsed time")

    // A stack rejection implies a nonzero depth
    `RQC_ASSERT(a_stack, aclk, aresetn, (m_tvalid && st == ST_STACK) |-> (m_tdata[115:100] != '0), "stack rejection at zero depth")

endmodule

bind resource_quota_checker rqc_checker u_rqc_checker (.*);

/* tb/resource_quota_checker_check.sv */
`timescale 1ns / 1ps

// Watches the configuration port and both streams, tracks quota counters and limits,
// and compares every result against the report owed for the oldest open request.
module resource_quota_checker_check
    import rqc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // [47:0] amount
    input  logic [S_TUSER_W-1:0]  s_tuser,  // [2:0] op
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] status, [3] time_expired, [51:4] memory_in_use, [99:52] instructions_done,
    // [115:100] frame_depth, [147:116] elapsed_ms, [151:148] zero
    input  logic [M_TDATA_W-1:0]  m_tdata,
    output int                    owed,
    output int                    mismatches
);

    localparam int RES_W = $bits(rqc_result_t);

    localparam logic [MEM_W-1:0]   MEM_TOP   = '1;
    localparam logic [INSTR_W-1:0] INSTR_TOP = '1;
    localparam logic [DEPTH_W-1:0] DEPTH_TOP = '1;
    localparam logic [TIME_W-1:0]  TIME_TOP  = '1;

    rqc_cfg_t           limits;
    logic [MEM_W-1:0]   mem_used;
    logic [INSTR_W-1:0] instr_cnt;
    logic [DEPTH_W-1:0] depth_cnt;
    logic [TIME_W-1:0]  ms_elapsed;
    rqc_result_t        reports_due[$];
    int                 err_cnt = 0;

    // Apply one event to the tracked counters and build the report it yields
    function automatic rqc_result_t quota_event(input logic [OP_W-1:0] op,
                                                input logic [AMOUNT_W-1:0] amount);
        logic [MEM_W:0] sum;
        rqc_result_t    rep;
        rep = '0;
        rep.status = ST_OK;
        case (op)
            OP_ALLOC: begin
                sum = {1'b0, mem_used} + {1'b0, amount};
                if (limits.max_single_alloc != '0 && amount > limits.max_single_alloc) begin
                    rep.status = ST_ALLOC_BIG;
                end else if (limits.max_memory_total == '0) begin
                    mem_used = sum[MEM_W] ? MEM_TOP : sum[MEM_W-1:0];
                end else if (sum > {1'b0, limits.max_memory_total}) begin
                    rep.status = ST_MEM_LIMIT;
                end else begin
                    mem_used = sum[MEM_W-1:0];
                end
            end
            OP_FREE: begin
                mem_used = (amount > mem_used) ? '0 : mem_used - amount;
            end
            OP_EXEC: begin
                sum = {1'b0, instr_cnt} + {1'b0, amount};
                if (limits.max_instr_count != '0 && sum > {1'b0, limits.max_instr_count}) begin
                    rep.status = ST_INSTR_LIM;
                end
                instr_cnt = sum[INSTR_W] ? INSTR_TOP : sum[INSTR_W-1:0];
            end
            OP_PUSH: begin
                if (limits.max_frame_depth != '0 && depth_cnt >= limits.max_frame_depth) begin
                    rep.status = ST_STACK;
                end else if (depth_cnt != DEPTH_TOP) begin
                    depth_cnt = depth_cnt + 1'b1;
                end
            end
            OP_POP: begin
                if (depth_cnt != '0) depth_cnt = depth_cnt - 1'b1;
            end
            OP_TICK: begin
                if (ms_elapsed != TIME_TOP) ms_elapsed = ms_elapsed + 1'b1;
            end
            OP_CLEAR: begin
                mem_used   = '0;
                instr_cnt  = '0;
                depth_cnt  = '0;
                ms_elapsed = '0;
            end
            default: begin
            end
        endcase
        rep.time_expired      = (limits.max_time_ms != '0) && (ms_elapsed >= limits.max_time_ms);
        rep.memory_in_use     = mem_used;
        rep.instructions_done = instr_cnt;
        rep.frame_depth       = depth_cnt;
        rep.elapsed_ms        = ms_elapsed;
        return rep;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            err_cnt++;
        end
    endfunction

    // Track limits and counters, queue a report per request, compare per result
    always @(posedge aclk) begin : watch
        rqc_result_t want;
        rqc_result_t got;
        if (!aresetn) begin
            limits     = '0;
            mem_used   = '0;
            instr_cnt  = '0;
            depth_cnt  = '0;
            ms_elapsed = '0;
            reports_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_MAX_SINGLE_ALLOC: limits.max_single_alloc = cfg_wdata[MEM_W-1:0];
                    CFG_MAX_MEMORY_TOTAL: limits.max_memory_total = cfg_wdata[MEM_W-1:0];
                    CFG_MAX_INSTR_COUNT:  limits.max_instr_count  = cfg_wdata[INSTR_W-1:0];
                    CFG_MAX_FRAME_DEPTH:  limits.max_frame_depth  = cfg_wdata[DEPTH_W-1:0];
                    CFG_MAX_TIME_MS:      limits.max_time_ms      = cfg_wdata[TIME_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (s_tvalid && s_tready) begin
                reports_due.push_back(quota_event(s_tuser, s_tdata[AMOUNT_W-1:0]));
            end

            if (m_tvalid && m_tready) begin
                got = rqc_result_t'(m_tdata[RES_W-1:0]);
                if (reports_due.size() == 0) begin
                    $error("result with no request outstanding: 0x%0h", m_tdata);
                    err_cnt++;
                end else begin
                    want = reports_due.pop_front();
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("time_expired", 64'(want.time_expired), 64'(got.time_expired));
                    check_field("memory_in_use", 64'(want.memory_in_use),
                                64'(got.memory_in_use));
                    check_field("instructions_done", 64'(want.instructions_done),
                                64'(got.instructions_done));
                    check_field("frame_depth", 64'(want.frame_depth), 64'(got.frame_depth));
                    check_field("elapsed_ms", 64'(want.elapsed_ms), 64'(got.elapsed_ms));
                    check_field("pad", 64'(0), 64'(m_tdata[M_TDATA_W-1:RES_W]));
                end
            end
        end
        owed       <= reports_due.size();
        mismatches <= err_cnt;
    end

endmodule

/* tb/resource_quota_checker_tb.sv */
`timescale 1ns / 1ps

// Drives quota events and limit settings into the checker block and gives the verdict.
module resource_quota_checker_tb;
    import rqc_pkg::*;

    // Indexes above the last register are ignored by the block
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_SPARE = 3'd5;
    // Op code seven is unused: no state change, status ok
    localparam logic [OP_W-1:0]       OP_SPARE        = 3'd7;
    localparam logic [47:0]           ONES48          = '1;
    localparam longint                TIMEOUT_NS      = 64'd40_000_000;
    localparam int                    RAND_PHASES     = 7;
    localparam int                    PHASE_ITEMS     = 250;
    localparam int                    LONG_STALL      = 400;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;  // [47:0] amount
    logic [S_TUSER_W-1:0]  s_tuser   = '0;  // [2:0] op
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // [2:0] status, [3] time_expired, [51:4] memory_in_use, [99:52] instructions_done,
    // [115:100] frame_depth, [147:116] elapsed_ms, [151:148] zero
    logic [M_TDATA_W-1:0]  m_tdata;

    int owed_cnt;
    int err_cnt;

    bit tx_quiet      = 1'b0;
    bit rx_quiet      = 1'b0;
    bit rx_long_stall = 1'b0;

    resource_quota_checker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    resource_quota_checker_check u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .owed       (owed_cnt),
        .mismatches (err_cnt)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

    // Result side: random ready gaps, one long hold-off on request
    initial begin : result_sink
        int gap;
        wait (aresetn);
        forever begin
            if (rx_long_stall) begin
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
                rx_long_stall = 1'b0;
            end
            gap = rx_quiet ? 0 : $urandom_range(0, 3);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    function automatic logic [47:0] rand_limit();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 48'd1;
            2: return 48'($urandom_range(2, 64));
            3: return 48'($urandom_range(65, 100000));
            4: return ONES48;
            default: return rand48();
        endcase
    endfunction

    // Mix tiny, huge, near-top and limit-sized amounts
    function automatic logic [47:0] rand_amount(input logic [47:0] scale);
        case ($urandom_range(0, 6))
            0: return 48'($urandom_range(0, 15));
            1: return 48'($urandom_range(0, 4095));
            2: return rand48();
            3: return ONES48 - 48'($urandom_range(0, 15));
            4, 5: begin
                if (scale == '0 || scale == ONES48) return rand48();
                return rand48() % (scale + 48'd1);
            end
            default: return 48'($urandom);
        endcase
    endfunction

    function automatic logic [OP_W-1:0] rand_op();
        int w;
        w = $urandom_range(0, 99);
        if (w < 20) return OP_ALLOC;
        if (w < 32) return OP_FREE;
        if (w < 50) return OP_EXEC;
        if (w < 65) return OP_PUSH;
        if (w < 75) return OP_POP;
        if (w < 93) return OP_TICK;
        if (w < 96) return OP_CLEAR;
        return OP_SPARE;
    endfunction

    // Offer one request and hold it until taken
    task automatic send_event(input logic [OP_W-1:0] op, input logic [47:0] amount);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= amount;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    // Drop valid and wait until every owed result is back, then let the pipe empty
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (owed_cnt != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [47:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Write all limits plus one ignored index; block must be idle
    task automatic set_limits(input logic [47:0] single, input logic [47:0] total,
                              input logic [47:0] instr, input logic [47:0] depth,
                              input logic [47:0] ms);
        write_reg(CFG_MAX_SINGLE_ALLOC, single);
        write_reg(CFG_MAX_MEMORY_TOTAL, total);
        write_reg(CFG_MAX_INSTR_COUNT, instr);
        write_reg(CFG_MAX_FRAME_DEPTH, depth);
        write_reg(CFG_MAX_TIME_MS, ms);
        write_reg(CFG_ADDR_W'(CFG_FIRST_SPARE + $urandom_range(0, 2)), rand48());
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin : stimulus
        logic [47:0] scale;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: size, total, instruction, depth and time limits at their edges
        set_limits(48'd100, 48'd300, 48'd1000, 48'd2, 48'd3);
        send_event(OP_ALLOC, 48'd0);
        send_event(OP_ALLOC, 48'd100);
        send_event(OP_ALLOC, 48'd101);
        send_event(OP_ALLOC, 48'd100);
        send_event(OP_ALLOC, 48'd100);
        send_event(OP_ALLOC, 48'd1);
        send_event(OP_FREE, 48'd50);
        send_event(OP_FREE, ONES48);
        send_event(OP_EXEC, 48'd999);
        send_event(OP_EXEC, 48'd1);
        send_event(OP_EXEC, 48'd1);
        send_event(OP_PUSH, '0);
        send_event(OP_PUSH, '0);
        send_event(OP_PUSH, '0);
        send_event(OP_POP, '0);
        send_event(OP_POP, '0);
        send_event(OP_POP, '0);
        send_event(OP_TICK, '0);
        send_event(OP_TICK, '0);
        send_event(OP_TICK, '0);
        send_event(OP_SPARE, ONES48);
        send_event(OP_CLEAR, ONES48);
        settle();

        // Directed: total check near the top must not wrap, instructions saturate
        set_limits('0, ONES48, '0, '0, '0);
        send_event(OP_ALLOC, ONES48 - 48'd5);
        send_event(OP_ALLOC, ONES48);
        send_event(OP_EXEC, ONES48);
        send_event(OP_EXEC, 48'd7);
        send_event(OP_CLEAR, '0);
        settle();

        // Cap the stack at one frame, then pop past empty
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        set_limits('0, '0, '0, 48'd1, '0);
        send_event(OP_PUSH, rand48());
        send_event(OP_PUSH, '0);
        send_event(OP_POP, '0);
        send_event(OP_POP, '0);
        send_event(OP_PUSH, '0);
        send_event(OP_CLEAR, '0);
        settle();

        // Random phases under several limit settings
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin
                    set_limits('0, '0, '0, '0, '0);
                    scale = '0;
                end
                1: begin
                    set_limits(ONES48, ONES48, ONES48, ONES48, ONES48);
                    scale = ONES48;
                end
                2: begin
                    scale = 48'($urandom_range(1, 20000));
                    set_limits(48'($urandom_range(1, 5000)), scale,
                               48'($urandom_range(1, 50000)),
                               48'($urandom_range(1, 12)), 48'($urandom_range(1, 40)));
                end
                default: begin
                    scale = rand_limit();
                    set_limits(rand_limit(), scale, rand_limit(), rand_limit(), rand_limit());
                end
            endcase
            tx_quiet = (ph == 3);
            rx_quiet = (ph == 3) || (ph == 5);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 4 && i == 40) rx_long_stall = 1'b1;
                if (ph == 2 && i == 125) settle();
                send_event(rand_op(), rand_amount(scale));
            end
            settle();
        end

        repeat (8) @(posedge aclk);
        if (err_cnt == 0 && owed_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/rqc_pkg.sv
hdl/rqc_cfg_regs.sv
hdl/rqc_engine.sv
hdl/resource_quota_checker.sv
hdl/rqc_checker.sv
tb/resource_quota_checker_check.sv
tb/resource_quota_checker_tb.sv
